>>> rtl/core/rsi_pkg.sv
// rsi_pkg: shared constants and width helpers for the ray/sphere intersect block
// used by ray_sphere_intersect and rsi_sqrt; no dependencies
package rsi_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF   = 12;

  // world scale and sphere size are both unsigned Q8.8
  localparam int SCALE_W    = 16;
  localparam int SCALE_FRAC = 8;
  localparam int SIZE_W     = 16;
  localparam int SIZE_FRAC  = 8;

  // ray direction is signed Q1.14
  localparam int DIR_W    = 16;
  localparam int DIR_FRAC = 14;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

  // width of the discriminant fed to the square root, rounded up to even
  // b*b takes 2*(cw+12) bits, r*r takes 2*(16+fb) bits, plus one for their sum
  function automatic int rad_width(input int cw, input int fb);
    int bw;
    int rw;
    int pw;
    bw = 2 * cw + 24;
    rw = 32 + 2 * fb;
    pw = ((bw > rw) ? bw : rw) + 1;
    return pw + (pw % 2);
  endfunction

  localparam int RAD_W_DEF = rad_width(COORD_WIDTH_DEF, FRAC_BITS_DEF);
  // sideband through the root pipe: miss flag and b
  localparam int TAG_W_DEF = COORD_WIDTH_DEF + 14;

endpackage

>>> rtl/core/rsi_sqrt.sv
// rsi_sqrt: pipelined integer square root, one result bit per register stage
// stalls per stage with valid/ready; width defaults from rsi_pkg
module rsi_sqrt #(
  parameter int RAD_W = rsi_pkg::RAD_W_DEF,
  parameter int TAG_W = rsi_pkg::TAG_W_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [RAD_W-1:0]     in_rad,
  input  logic [TAG_W-1:0]     in_tag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [RAD_W/2-1:0]   out_root,
  output logic [TAG_W-1:0]     out_tag
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  logic [ROOT_W-1:0]              v_r;
  logic [ROOT_W-1:0]              en;
  logic [ROOT_W-1:0][REM_W-1:0]   rem_r;
  logic [ROOT_W-1:0][ROOT_W-1:0]  root_r;
  logic [ROOT_W-1:0][RAD_W-1:0]   rad_r;
  logic [ROOT_W-1:0][TAG_W-1:0]   tag_r;

  logic [ROOT_W-1:0]              p_v;
  logic [ROOT_W-1:0][REM_W-1:0]   p_rem;
  logic [ROOT_W-1:0][ROOT_W-1:0]  p_root;
  logic [ROOT_W-1:0][RAD_W-1:0]   p_rad;
  logic [ROOT_W-1:0][TAG_W-1:0]   p_tag;

  logic [ROOT_W-1:0][REM_W-1:0]   rem_sh;
  logic [ROOT_W-1:0][REM_W-1:0]   trial;
  logic [ROOT_W-1:0]              ge;
  logic [ROOT_W-1:0][REM_W-1:0]   rem_nxt;
  logic [ROOT_W-1:0][ROOT_W-1:0]  root_nxt;
  logic [ROOT_W-1:0][RAD_W-1:0]   rad_nxt;

  // each stage sees the previous stage's registers, stage 0 sees the input
  always_comb begin
    p_v[0]    = in_valid;
    p_rem[0]  = '0;
    p_root[0] = '0;
    p_rad[0]  = in_rad;
    p_tag[0]  = in_tag;
    for (int i = 1; i < ROOT_W; i++) begin
      p_v[i]    = v_r[i-1];
      p_rem[i]  = rem_r[i-1];
      p_root[i] = root_r[i-1];
      p_rad[i]  = rad_r[i-1];
      p_tag[i]  = tag_r[i-1];
    end
  end

  // restoring digit step: bring down two radicand bits, try 4*root+1
  always_comb begin
    for (int i = 0; i < ROOT_W; i++) begin
      rem_sh[i]   = {p_rem[i][REM_W-3:0], p_rad[i][RAD_W-1 -: 2]};
      trial[i]    = {p_root[i], 2'b01};
      ge[i]       = (rem_sh[i] >= trial[i]);
      rem_nxt[i]  = ge[i] ? (rem_sh[i] - trial[i]) : rem_sh[i];
      root_nxt[i] = {p_root[i][ROOT_W-2:0], ge[i]};
      rad_nxt[i]  = {p_rad[i][RAD_W-3:0], 2'b00};
    end
  end

  // a stage loads when it is empty or its content moves on
  genvar g;
  for (g = 0; g < ROOT_W; g++) begin : g_en
    if (g == ROOT_W - 1) begin : g_last
      assign en[g] = !v_r[g] || out_ready;
    end else begin : g_mid
      assign en[g] = !v_r[g] || en[g+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < ROOT_W; i++) begin
        if (en[i]) begin
          v_r[i] <= p_v[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ROOT_W; i++) begin
      if (en[i]) begin
        rem_r[i]  <= rem_nxt[i];
        root_r[i] <= root_nxt[i];
        rad_r[i]  <= rad_nxt[i];
        tag_r[i]  <= p_tag[i];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_tag   = tag_r[ROOT_W-1];

endmodule

>>> rtl/core/ray_sphere_intersect.sv
// ray_sphere_intersect: fully pipelined ray/sphere hit test with nearest positive distance,
// built on rsi_pkg for constants and rsi_sqrt for the square root pipe
// eight arithmetic stages, one stage per root bit and one output stage; RAD_W is
//   max(2*COORD_WIDTH+24, 32+2*FRAC_BITS)+1 rounded up to even
// throughput: one beat per cycle; every stage stalls on its own, so bubbles are squeezed out
module ray_sphere_intersect #(
  parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_WIDTH-1:0]       in_origin_x,
  input  logic signed [COORD_WIDTH-1:0]       in_origin_y,
  input  logic signed [COORD_WIDTH-1:0]       in_origin_z,
  input  logic signed [rsi_pkg::DIR_W-1:0]    in_dir_x,
  input  logic signed [rsi_pkg::DIR_W-1:0]    in_dir_y,
  input  logic signed [rsi_pkg::DIR_W-1:0]    in_dir_z,
  input  logic signed [COORD_WIDTH-1:0]       in_center_x,
  input  logic signed [COORD_WIDTH-1:0]       in_center_y,
  input  logic signed [COORD_WIDTH-1:0]       in_center_z,
  input  logic [rsi_pkg::SIZE_W-1:0]          in_sphere_size,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_hit,
  output logic [COORD_WIDTH-1:0]              out_distance,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rsi_pkg::SCALE_W-1:0]         cfg_world_scale
);

  localparam int W    = COORD_WIDTH;
  localparam int CPW  = W + rsi_pkg::SCALE_W + 1;                 // center * scale
  localparam int PCW  = W + rsi_pkg::SCALE_W - rsi_pkg::SCALE_FRAC; // scaled center
  localparam int DPW  = PCW + 1;                                   // origin - center
  localparam int MW   = DPW - 1;                                   // |dp|
  localparam int MLO  = (MW + 1) / 2;
  localparam int MHI  = MW - MLO;
  localparam int SQW  = 2 * MW;
  localparam int M2W  = SQW + 2;
  localparam int PPW  = DPW + rsi_pkg::DIR_W;                      // dp * dir
  localparam int DTW  = PPW + 2;
  localparam int BW   = DTW - rsi_pkg::DIR_FRAC;
  localparam int BMW  = BW - 1;                                    // |b|
  localparam int BLO  = (BMW + 1) / 2;
  localparam int BHI  = BMW - BLO;
  localparam int B2W  = 2 * BMW;
  localparam int RFW  = rsi_pkg::SIZE_W + rsi_pkg::SCALE_W;
  localparam int RSH  = rsi_pkg::SIZE_FRAC + rsi_pkg::SCALE_FRAC - FRAC_BITS;
  localparam int RW   = RFW - RSH;
  localparam int R2W  = 2 * RW;
  localparam int PW   = ((B2W > R2W) ? B2W : R2W) + 1;
  localparam int RADW = rsi_pkg::rad_width(W, FRAC_BITS);
  localparam int ROOTW = RADW / 2;
  localparam int TAGW = BW + 1;
  localparam int TW   = ((ROOTW > BW) ? ROOTW : BW) + 2;

  // configuration
  logic [rsi_pkg::SCALE_W-1:0] scale_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= rsi_pkg::SCALE_RESET;
    end else if (cfg_valid) begin
      scale_r <= cfg_world_scale;
    end
  end

  // stage enables, chained back from the output register
  logic s1_en, s2_en, s3_en, s4_en, s5_en, s6_en, s7_en, s8_en, o_en;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r, s8_v_r;
  logic out_valid_r;
  logic sq_in_ready, sq_out_valid;
  logic [ROOTW-1:0] sq_root;
  logic [TAGW-1:0]  sq_tag;

  assign o_en     = !out_valid_r || out_ready;
  assign s8_en    = !s8_v_r || sq_in_ready;
  assign s7_en    = !s7_v_r || s8_en;
  assign s6_en    = !s6_v_r || s7_en;
  assign s5_en    = !s5_v_r || s6_en;
  assign s4_en    = !s4_v_r || s5_en;
  assign s3_en    = !s3_v_r || s4_en;
  assign s2_en    = !s2_v_r || s3_en;
  assign s1_en    = !s1_v_r || s2_en;
  assign in_ready = s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      s6_v_r      <= 1'b0;
      s7_v_r      <= 1'b0;
      s8_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_en) s1_v_r <= in_valid;
      if (s2_en) s2_v_r <= s1_v_r;
      if (s3_en) s3_v_r <= s2_v_r;
      if (s4_en) s4_v_r <= s3_v_r;
      if (s5_en) s5_v_r <= s4_v_r;
      if (s6_en) s6_v_r <= s5_v_r;
      if (s7_en) s7_v_r <= s6_v_r;
      if (s8_en) s8_v_r <= s7_v_r;
      if (o_en)  out_valid_r <= sq_out_valid;
    end
  end

  // stage 1: scale center and radius
  logic signed [W-1:0]                 o_in   [3];
  logic signed [W-1:0]                 c_in   [3];
  logic signed [rsi_pkg::DIR_W-1:0]    d_in   [3];
  logic signed [CPW-1:0]               cprod  [3];
  logic signed [PCW-1:0]               pc_s1_nxt [3];
  logic [RFW-1:0]                      rf_s1_nxt;

  logic signed [W-1:0]                 o_s1_r   [3];
  logic signed [PCW-1:0]               pc_s1_r  [3];
  logic signed [rsi_pkg::DIR_W-1:0]    dir_s1_r [3];
  logic [RFW-1:0]                      rf_s1_r;

  always_comb begin
    o_in[0] = in_origin_x;
    o_in[1] = in_origin_y;
    o_in[2] = in_origin_z;
    c_in[0] = in_center_x;
    c_in[1] = in_center_y;
    c_in[2] = in_center_z;
    d_in[0] = in_dir_x;
    d_in[1] = in_dir_y;
    d_in[2] = in_dir_z;
    for (int a = 0; a < 3; a++) begin
      cprod[a]     = c_in[a] * $signed({1'b0, scale_r});
      // floor division by 256 is the arithmetic shift
      pc_s1_nxt[a] = cprod[a][CPW-2:rsi_pkg::SCALE_FRAC];
    end
    rf_s1_nxt = RFW'(in_sphere_size) * RFW'(scale_r);
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      for (int a = 0; a < 3; a++) begin
        o_s1_r[a]   <= o_in[a];
        pc_s1_r[a]  <= pc_s1_nxt[a];
        dir_s1_r[a] <= d_in[a];
      end
      rf_s1_r <= rf_s1_nxt;
    end
  end

  // stage 2: offset from the center, radius alignment
  logic signed [DPW-1:0]               dp_s2_nxt [3];
  logic signed [DPW-1:0]               dp_s2_r   [3];
  logic signed [rsi_pkg::DIR_W-1:0]    dir_s2_r  [3];
  logic [RW-1:0]                       r_s2_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dp_s2_nxt[a] = {{(DPW-W){o_s1_r[a][W-1]}}, o_s1_r[a]}
                   - {pc_s1_r[a][PCW-1], pc_s1_r[a]};
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      for (int a = 0; a < 3; a++) begin
        dp_s2_r[a]  <= dp_s2_nxt[a];
        dir_s2_r[a] <= dir_s1_r[a];
      end
      r_s2_r <= rf_s1_r[RFW-1:RSH];
    end
  end

  // stage 3: dot products and split squares of |dp|
  logic signed [PPW-1:0]  dotp_s3_nxt [3];
  logic [DPW-1:0]         dpa   [3];
  logic [MHI-1:0]         dmh   [3];
  logic [MLO-1:0]         dml   [3];
  logic [2*MHI-1:0]       hh_s3_nxt [3];
  logic [MW-1:0]          hl_s3_nxt [3];
  logic [2*MLO-1:0]       ll_s3_nxt [3];
  logic [R2W-1:0]         rsq_s3_nxt;

  logic signed [PPW-1:0]  dotp_s3_r [3];
  logic [2*MHI-1:0]       hh_s3_r   [3];
  logic [MW-1:0]          hl_s3_r   [3];
  logic [2*MLO-1:0]       ll_s3_r   [3];
  logic [R2W-1:0]         rsq_s3_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dotp_s3_nxt[a] = dp_s2_r[a] * dir_s2_r[a];
      dpa[a]         = dp_s2_r[a][DPW-1] ? (~dp_s2_r[a] + 1'b1) : dp_s2_r[a];
      dmh[a]         = dpa[a][MW-1:MLO];
      dml[a]         = dpa[a][MLO-1:0];
      hh_s3_nxt[a]   = dmh[a] * dmh[a];
      hl_s3_nxt[a]   = dmh[a] * dml[a];
      ll_s3_nxt[a]   = dml[a] * dml[a];
    end
    rsq_s3_nxt = r_s2_r * r_s2_r;
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      for (int a = 0; a < 3; a++) begin
        dotp_s3_r[a] <= dotp_s3_nxt[a];
        hh_s3_r[a]   <= hh_s3_nxt[a];
        hl_s3_r[a]   <= hl_s3_nxt[a];
        ll_s3_r[a]   <= ll_s3_nxt[a];
      end
      rsq_s3_r <= rsq_s3_nxt;
    end
  end

  // stage 4: b from the dot product, per-axis squares recombined
  logic [DTW-1:0]         dot_sum;
  logic signed [BW-1:0]   b_s4_nxt;
  logic [SQW-1:0]         sq_s4_nxt [3];

  logic signed [BW-1:0]   b_s4_r;
  logic [SQW-1:0]         sq_s4_r [3];
  logic [R2W-1:0]         rsq_s4_r;

  always_comb begin
    dot_sum = {{2{dotp_s3_r[0][PPW-1]}}, dotp_s3_r[0]}
            + {{2{dotp_s3_r[1][PPW-1]}}, dotp_s3_r[1]}
            + {{2{dotp_s3_r[2][PPW-1]}}, dotp_s3_r[2]};
    b_s4_nxt = dot_sum[DTW-1:rsi_pkg::DIR_FRAC];
    for (int a = 0; a < 3; a++) begin
      sq_s4_nxt[a] = (SQW'(hh_s3_r[a]) << (2 * MLO))
                   + (SQW'(hl_s3_r[a]) << (MLO + 1))
                   + SQW'(ll_s3_r[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (s4_en) begin
      b_s4_r <= b_s4_nxt;
      for (int a = 0; a < 3; a++) begin
        sq_s4_r[a] <= sq_s4_nxt[a];
      end
      rsq_s4_r <= rsq_s3_r;
    end
  end

  // stage 5: |dp|^2 and split squares of |b|
  logic [M2W-1:0]         mag2_s5_nxt;
  logic [BW-1:0]          ba;
  logic [BHI-1:0]         bmh;
  logic [BLO-1:0]         bml;
  logic [2*BHI-1:0]       bhh_s5_nxt;
  logic [BMW-1:0]         bhl_s5_nxt;
  logic [2*BLO-1:0]       bll_s5_nxt;

  logic [M2W-1:0]         mag2_s5_r;
  logic [2*BHI-1:0]       bhh_s5_r;
  logic [BMW-1:0]         bhl_s5_r;
  logic [2*BLO-1:0]       bll_s5_r;
  logic signed [BW-1:0]   b_s5_r;
  logic [R2W-1:0]         rsq_s5_r;

  always_comb begin
    mag2_s5_nxt = M2W'(sq_s4_r[0]) + M2W'(sq_s4_r[1]) + M2W'(sq_s4_r[2]);
    ba          = b_s4_r[BW-1] ? (~b_s4_r + 1'b1) : b_s4_r;
    bmh         = ba[BMW-1:BLO];
    bml         = ba[BLO-1:0];
    bhh_s5_nxt  = bmh * bmh;
    bhl_s5_nxt  = bmh * bml;
    bll_s5_nxt  = bml * bml;
  end

  always_ff @(posedge clk) begin
    if (s5_en) begin
      mag2_s5_r <= mag2_s5_nxt;
      bhh_s5_r  <= bhh_s5_nxt;
      bhl_s5_r  <= bhl_s5_nxt;
      bll_s5_r  <= bll_s5_nxt;
      b_s5_r    <= b_s4_r;
      rsq_s5_r  <= rsq_s4_r;
    end
  end

  // stage 6: b squared
  logic [B2W-1:0]         b2_s6_nxt;
  logic [B2W-1:0]         b2_s6_r;
  logic [M2W-1:0]         mag2_s6_r;
  logic [R2W-1:0]         rsq_s6_r;
  logic signed [BW-1:0]   b_s6_r;

  assign b2_s6_nxt = (B2W'(bhh_s5_r) << (2 * BLO))
                   + (B2W'(bhl_s5_r) << (BLO + 1))
                   + B2W'(bll_s5_r);

  always_ff @(posedge clk) begin
    if (s6_en) begin
      b2_s6_r   <= b2_s6_nxt;
      mag2_s6_r <= mag2_s5_r;
      rsq_s6_r  <= rsq_s5_r;
      b_s6_r    <= b_s5_r;
    end
  end

  // stage 7: b^2 + r^2
  logic [PW-1:0]          pos_s7_nxt;
  logic [PW-1:0]          pos_s7_r;
  logic [M2W-1:0]         mag2_s7_r;
  logic signed [BW-1:0]   b_s7_r;

  assign pos_s7_nxt = PW'(b2_s6_r) + PW'(rsq_s6_r);

  always_ff @(posedge clk) begin
    if (s7_en) begin
      pos_s7_r  <= pos_s7_nxt;
      mag2_s7_r <= mag2_s6_r;
      b_s7_r    <= b_s6_r;
    end
  end

  // stage 8: discriminant, borrow out means a miss
  logic [PW:0]            disc;
  logic [RADW-1:0]        rad_s8_nxt;
  logic [TAGW-1:0]        tag_s8_nxt;
  logic [RADW-1:0]        rad_s8_r;
  logic [TAGW-1:0]        tag_s8_r;

  always_comb begin
    disc       = {1'b0, pos_s7_r} - (PW+1)'(mag2_s7_r);
    rad_s8_nxt = RADW'(disc[PW-1:0]);
    tag_s8_nxt = {disc[PW], b_s7_r};
  end

  always_ff @(posedge clk) begin
    if (s8_en) begin
      rad_s8_r <= rad_s8_nxt;
      tag_s8_r <= tag_s8_nxt;
    end
  end

  rsi_sqrt #(
    .RAD_W (RADW),
    .TAG_W (TAGW)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s8_v_r),
    .in_ready  (sq_in_ready),
    .in_rad    (rad_s8_r),
    .in_tag    (tag_s8_r),
    .out_valid (sq_out_valid),
    .out_ready (o_en),
    .out_root  (sq_root),
    .out_tag   (sq_tag)
  );

  // output stage: roots s - b and -s - b, pick the nearest positive one
  logic                   miss;
  logic signed [TW-1:0]   sx;
  logic signed [TW-1:0]   bx;
  logic signed [TW-1:0]   t1;
  logic signed [TW-1:0]   t2;
  logic signed [TW-1:0]   tsel;
  logic                   t1_pos;
  logic                   t2_pos;
  logic                   hit_nxt;
  logic [W-1:0]           dist_nxt;
  logic                   hit_r;
  logic [W-1:0]           dist_r;

  always_comb begin
    miss   = sq_tag[TAGW-1];
    sx     = $signed({{(TW-ROOTW){1'b0}}, sq_root});
    bx     = $signed({{(TW-BW){sq_tag[BW-1]}}, sq_tag[BW-1:0]});
    t1     = sx - bx;
    t2     = -sx - bx;
    t1_pos = !t1[TW-1] && (t1 != '0);
    t2_pos = !t2[TW-1] && (t2 != '0);
    tsel   = t2_pos ? t2 : t1;
    // t1 >= t2, so a hit needs only t1 positive
    hit_nxt = !miss && t1_pos;
    if (!hit_nxt) begin
      dist_nxt = '0;
    end else if (tsel[TW-1:W] != '0) begin
      dist_nxt = '1;
    end else begin
      dist_nxt = tsel[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (o_en) begin
      hit_r  <= hit_nxt;
      dist_r <= dist_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = hit_r;
  assign out_distance = dist_r;

endmodule
